>>> hw/rtl/frame_table_aging_replacement_macros.svh
// Assertion macros for the frame table block.
// Included by modules that carry concurrent checks.
`ifndef FRAME_TABLE_AGING_REPLACEMENT_MACROS_SVH
`define FRAME_TABLE_AGING_REPLACEMENT_MACROS_SVH
`ifndef SYNTHESIS
`define FTA_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define FTA_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define FTA_ASSERT(label, clk, rstn, prop)
`define FTA_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

>>> hw/rtl/fta_pkg.sv
// Shared types and codes for the frame table block.
// No dependencies.
`default_nettype none
package fta_pkg;
    typedef enum logic [2:0] {
        CMD_ALLOC      = 3'd0,
        CMD_FREE       = 3'd1,
        CMD_FREE_OWNER = 3'd2,
        CMD_SET_DONE   = 3'd3,
        CMD_ACCESS     = 3'd4,
        CMD_TICK       = 3'd5
    } cmd_t;
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_REFUSED   = 2'd1,
        ST_NO_VICTIM = 2'd2,
        ST_NOT_VALID = 2'd3
    } status_t;
    localparam int CFG_W = 11;
    localparam int DIV_W = 10;
    localparam logic [CFG_W-1:0] PERIOD_MAX = 11'd1024;
    localparam int PAGE_W = 20;
    localparam int OWNER_W = 16;
    localparam int FIDX_W = 6;
endpackage
`default_nettype wire

>>> hw/rtl/fta_age_cmp.sv
// Shared compare unit: is a candidate's age below the best so far, or is there no best yet.
// Uses no package items.
`default_nettype none
module fta_age_cmp #(
    parameter int AGE_BITS = 8
) (
    input  wire logic [AGE_BITS-1:0] cand_age,
    input  wire logic [AGE_BITS-1:0] best_age,
    input  wire logic                have_best,
    output logic                     better
);
    assign better = !have_best || (cand_age < best_age);
endmodule
`default_nettype wire

>>> hw/rtl/frame_table_aging_replacement.sv
// Frame table with aging replacement. Each command is one word in and one word
// out, and the block takes no new word until the result has been taken. From one
// accept to the next, single-frame commands (free, set done, mark accessed, refused
// allocate, ticks that do not age, unused codes) pass through accept, table update
// and answer. Free owner and an aging tick sweep every frame, one per cycle through
// a single shared scan unit. Allocate stops at the first free frame; with no free
// frame it sweeps all frames through the same scan and the age-compare unit, and
// when it evicts it reads the victim and rewrites it before the answer. Owner, page
// and age live in memories read at one address a cycle.
// Depends on fta_pkg, fta_age_cmp and the macros header.
`default_nettype none
`include "frame_table_aging_replacement_macros.svh"
module frame_table_aging_replacement #(
    parameter int NUM_FRAMES = 64,
    parameter int AGE_BITS   = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [10:0] cfg_wr_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // command[2:0], page_number[22:3], owner_id[38:23], frame_index[44:39],
    // flag_value[45], user_pool[46], zero[47]
    input  wire logic [47:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // status[1:0], granted_frame[7:2], evicted[8], victim_owner[24:9],
    // victim_page[44:25], zero[47:45]
    output logic [47:0]      m_tdata
);
    import fta_pkg::*;
    localparam int IW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int CW = IW + 1;
    localparam logic [CW-1:0] LAST = CW'(NUM_FRAMES - 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001, S_RD = 6'b000010, S_SCAN = 6'b000100,
        S_EVRD = 6'b001000, S_EVWR = 6'b010000, S_OUT = 6'b100000
    } state_t;
    state_t state_reg, state_next;

    logic [NUM_FRAMES-1:0] valid_reg, done_reg, ref_reg;
    logic [AGE_BITS-1:0] age_mem [NUM_FRAMES];
    logic [AGE_BITS-1:0] age_rd_reg, best_age_reg;
    logic [OWNER_W-1:0] own_mem [NUM_FRAMES];
    logic [PAGE_W-1:0]  page_mem [NUM_FRAMES];
    logic [OWNER_W-1:0] own_rd_reg;
    logic [PAGE_W-1:0]  page_rd_reg;
    logic [CFG_W-1:0] period_reg;
    logic [DIV_W-1:0] div_reg;
    logic [47:0] in_reg;
    logic [CW-1:0] cnt_reg;
    logic [IW-1:0] best_reg;
    logic have_reg, age_pass_reg;
    logic [47:0] out_reg;

    logic [2:0] cmd;
    logic [PAGE_W-1:0] pg;
    logic [OWNER_W-1:0] ow;
    logic [FIDX_W-1:0] fi;
    logic flag, user;
    assign cmd  = in_reg[2:0];
    assign pg   = in_reg[22:3];
    assign ow   = in_reg[38:23];
    assign fi   = in_reg[44:39];
    assign flag = in_reg[45];
    assign user = in_reg[46];

    logic [IW-1:0] ci;
    assign ci = cnt_reg[IW-1:0];
    logic [IW-1:0] fii;
    assign fii = IW'(fi);
    logic fi_ok;
    assign fi_ok = (32'(fi) < NUM_FRAMES) && valid_reg[fii];

    logic better;
    fta_age_cmp #(.AGE_BITS(AGE_BITS)) u_cmp (
        .cand_age(age_rd_reg), .best_age(best_age_reg),
        .have_best(have_reg), .better(better)
    );

    logic [CFG_W-1:0] per;
    always_comb begin
        per = period_reg;
        if (per == '0) per = CFG_W'(1);
        if (per > PERIOD_MAX) per = PERIOD_MAX;
    end
    logic tick_fire;
    assign tick_fire = (CFG_W'(div_reg) + CFG_W'(1)) >= per;

    function automatic logic [47:0] pack(logic [1:0] st, logic [IW-1:0] g, logic ev,
                                         logic [OWNER_W-1:0] vo, logic [PAGE_W-1:0] vp);
        logic [47:0] r;
        r = '0;
        r[1:0] = st;
        r[7:2] = FIDX_W'(g);
        r[8] = ev;
        r[24:9] = vo;
        r[44:25] = vp;
        return r;
    endfunction

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = out_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (s_tvalid) state_next = S_RD;
            S_RD: begin
                if ((cmd == CMD_ALLOC && user) || cmd == CMD_FREE_OWNER
                    || (cmd == CMD_TICK && tick_fire))
                    state_next = S_SCAN;
                else
                    state_next = S_OUT;
            end
            S_SCAN: begin
                if (cmd == CMD_ALLOC && !valid_reg[ci])
                    state_next = S_OUT;
                else if (cnt_reg == LAST)
                    state_next = (cmd == CMD_ALLOC && (have_reg ||
                                  (valid_reg[ci] && done_reg[ci]))) ? S_EVRD : S_OUT;
            end
            S_EVRD: state_next = S_EVWR;
            S_EVWR: state_next = S_OUT;
            S_OUT: if (m_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            done_reg <= '0;
            ref_reg <= '0;
            period_reg <= CFG_W'(1);
            div_reg <= '0;
            cnt_reg <= '0;
            have_reg <= 1'b0;
            best_reg <= '0;
            best_age_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) period_reg <= cfg_wr_data;
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) in_reg <= s_tdata;
                    cnt_reg <= '0;
                    have_reg <= 1'b0;
                    best_reg <= '0;
                    best_age_reg <= '0;
                end
                S_RD: begin
                    out_reg <= pack(ST_OK, '0, 1'b0, '0, '0);
                    unique case (cmd)
                        CMD_ALLOC: if (!user) out_reg <= pack(ST_REFUSED, '0, 1'b0, '0, '0);
                        CMD_FREE: begin
                            if (fi_ok) begin
                                valid_reg[fii] <= 1'b0;
                                done_reg[fii] <= 1'b0;
                                ref_reg[fii] <= 1'b0;
                            end else out_reg <= pack(ST_NOT_VALID, '0, 1'b0, '0, '0);
                        end
                        CMD_SET_DONE: begin
                            if (fi_ok) done_reg[fii] <= flag;
                            else out_reg <= pack(ST_NOT_VALID, '0, 1'b0, '0, '0);
                        end
                        CMD_ACCESS: begin
                            if (fi_ok) ref_reg[fii] <= 1'b1;
                            else out_reg <= pack(ST_NOT_VALID, '0, 1'b0, '0, '0);
                        end
                        CMD_TICK: begin
                            if (tick_fire) div_reg <= '0;
                            else div_reg <= div_reg + DIV_W'(1);
                        end
                        default: ;
                    endcase
                end
                S_SCAN: begin
                    cnt_reg <= cnt_reg + CW'(1);
                    unique case (cmd)
                        CMD_ALLOC: begin
                            if (!valid_reg[ci]) begin
                                valid_reg[ci] <= 1'b1;
                                done_reg[ci] <= 1'b0;
                                ref_reg[ci] <= 1'b0;
                                out_reg <= pack(ST_OK, ci, 1'b0, '0, '0);
                            end else begin
                                if (done_reg[ci] && better) begin
                                    have_reg <= 1'b1;
                                    best_reg <= ci;
                                    best_age_reg <= age_rd_reg;
                                end
                                if (cnt_reg == LAST && !(have_reg || done_reg[ci]))
                                    out_reg <= pack(ST_NO_VICTIM, '0, 1'b0, '0, '0);
                            end
                        end
                        CMD_FREE_OWNER: begin
                            if (valid_reg[ci] && own_rd_reg == ow) begin
                                valid_reg[ci] <= 1'b0;
                                done_reg[ci] <= 1'b0;
                                ref_reg[ci] <= 1'b0;
                            end
                        end
                        default: begin
                            if (valid_reg[ci]) ref_reg[ci] <= 1'b0;
                        end
                    endcase
                end
                S_EVRD: ;
                S_EVWR: begin
                    out_reg <= pack(ST_OK, best_reg, 1'b1, own_rd_reg, page_rd_reg);
                    done_reg[best_reg] <= 1'b0;
                    ref_reg[best_reg] <= 1'b0;
                end
                S_OUT: ;
                default: ;
            endcase
        end
    end

    // memory: read address is the next scan index, or the victim in eviction
    logic [IW-1:0] rd_addr;
    logic mem_we;
    logic [IW-1:0] wr_addr;
    logic age_we;
    logic [AGE_BITS-1:0] age_wd;
    always_comb begin
        rd_addr = (state_reg == S_SCAN && cnt_reg != LAST) ? IW'(cnt_reg + CW'(1)) : '0;
        if (state_reg == S_SCAN && cmd == CMD_ALLOC && cnt_reg == LAST) rd_addr = best_reg;
        if (state_reg == S_SCAN && cmd == CMD_ALLOC && cnt_reg == LAST
            && !have_reg) rd_addr = ci;
        if (state_reg == S_EVRD) rd_addr = best_reg;
        mem_we = (state_reg == S_SCAN && cmd == CMD_ALLOC && !valid_reg[ci])
              || (state_reg == S_EVWR);
        wr_addr = (state_reg == S_EVWR) ? best_reg : ci;
        // aging shifts the referenced bit in at the top; a new frame starts at zero
        age_we = mem_we || (state_reg == S_SCAN && cmd == CMD_TICK && valid_reg[ci]);
        age_wd = (state_reg == S_SCAN && cmd == CMD_TICK)
               ? {ref_reg[ci], age_rd_reg[AGE_BITS-1:1]} : '0;
    end
    // eviction winner on the last frame must land in best_reg before EVRD
    always_ff @(posedge aclk) begin
        if (!aresetn)
            age_pass_reg <= 1'b0;
        else if (state_reg == S_SCAN && cmd == CMD_ALLOC && cnt_reg == LAST
            && valid_reg[ci] && done_reg[ci] && better)
            age_pass_reg <= 1'b1;
        else
            age_pass_reg <= 1'b0;
    end
    always_ff @(posedge aclk) begin
        if (state_reg == S_RD) begin
            own_rd_reg <= own_mem[0];
            page_rd_reg <= page_mem[0];
            age_rd_reg <= age_mem[0];
        end else begin
            own_rd_reg <= own_mem[rd_addr];
            page_rd_reg <= page_mem[rd_addr];
            age_rd_reg <= age_mem[rd_addr];
        end
        if (mem_we) begin
            own_mem[wr_addr] <= ow;
            page_mem[wr_addr] <= pg;
        end
        if (age_we) age_mem[wr_addr] <= age_wd;
    end

    `FTA_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    `FTA_ASSERT(a_one_side, aclk, aresetn, !(s_tready && m_tvalid))
    `FTA_ASSERT(a_ev_valid, aclk, aresetn, state_reg == S_EVWR |-> valid_reg[best_reg] && have_reg)
    `FTA_ASSERT(a_pass_ev, aclk, aresetn, age_pass_reg |-> state_reg == S_EVRD)
endmodule
`default_nettype wire
